// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the step pulse generator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tspg_pkg.sv =====
// Package for the three-axis step pulse generator: sizes, request codes,
// reset values and the control/status structs between top and axis bank.
package tspg_pkg;

   localparam int AXES         = 3;
   localparam int PERIOD_WIDTH = 16;
   localparam int STEP_WIDTH   = 32;
   localparam int RATE_WIDTH   = 20;
   localparam int QUOT_WIDTH   = 20;
   localparam int AXIS_W       = 2;
   localparam int CNT_W        = $clog2(QUOT_WIDTH + 1);

   localparam logic [QUOT_WIDTH-1:0]   BASE_HZ       = QUOT_WIDTH'(1000000);
   localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET  = PERIOD_WIDTH'(1000 - 1);
   localparam logic [PERIOD_WIDTH-1:0] COMPARE_RESET = PERIOD_WIDTH'(500);
   localparam logic [63:0]             PERIOD_MAX    = (64'd1 << PERIOD_WIDTH) - 64'd1;

   localparam logic [2:0] REQ_TICK  = 3'd0;
   localparam logic [2:0] REQ_MOVE  = 3'd1;
   localparam logic [2:0] REQ_DIR   = 3'd2;
   localparam logic [2:0] REQ_RATE  = 3'd3;
   localparam logic [2:0] REQ_EN    = 3'd4;
   localparam logic [2:0] REQ_START = 3'd5;
   localparam logic [2:0] REQ_STOP  = 3'd6;

   typedef struct packed {
      logic                    roll;
      logic [AXES-1:0]         limits;
      logic                    load_rate;
      logic                    load_move;
      logic                    set_dir;
      logic                    set_en;
      logic [AXIS_W-1:0]       axis;
      logic                    flag;
      logic [PERIOD_WIDTH-1:0] compare;
      logic [STEP_WIDTH-1:0]   steps;
   } axis_ctl_type;

   typedef struct packed {
      logic [AXES-1:0] busy;
      logic [AXES-1:0] roll_busy;
      logic [AXES-1:0] forward;
      logic [AXES-1:0] dir;
      logic [AXES-1:0] enable;
      logic [AXES-1:0] step;
   } axis_stat_type;

endpackage

// ===== rtl/core/tspg_div.sv =====
// Shared bit-serial restoring divider: base frequency / rate, one quotient
// bit per cycle. Depends on tspg_pkg.
module tspg_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [tspg_pkg::RATE_WIDTH-1:0] divisor,
   output logic                            done,
   output logic [tspg_pkg::QUOT_WIDTH-1:0] quotient
);

   logic [tspg_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic                            done_ff, done_in;
   logic [tspg_pkg::RATE_WIDTH-1:0] div_ff, div_in;
   logic [tspg_pkg::RATE_WIDTH-1:0] rem_ff, rem_in;
   logic [tspg_pkg::QUOT_WIDTH-1:0] quo_ff, quo_in;
   logic [tspg_pkg::RATE_WIDTH:0]   shifted;
   logic [tspg_pkg::RATE_WIDTH:0]   diff;

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      shifted = {rem_ff, quo_ff[tspg_pkg::QUOT_WIDTH-1]};
      diff    = shifted - {1'b0, div_ff};
      if (start) begin
         cnt_in = tspg_pkg::CNT_W'(tspg_pkg::QUOT_WIDTH);
         div_in = divisor;
         rem_in = '0;
         quo_in = tspg_pkg::BASE_HZ;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == tspg_pkg::CNT_W'(1));
         if (!diff[tspg_pkg::RATE_WIDTH]) begin
            rem_in = diff[tspg_pkg::RATE_WIDTH-1:0];
            quo_in = {quo_ff[tspg_pkg::QUOT_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[tspg_pkg::RATE_WIDTH-1:0];
            quo_in = {quo_ff[tspg_pkg::QUOT_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/tspg_axes.sv =====
// Per-axis state bank: step counts, compare levels, direction, enable and
// rollover step logic. Depends on tspg_pkg.
module tspg_axes (
   input  logic                              clock,
   input  logic                              reset,
   input  tspg_pkg::axis_ctl_type            ctl,
   input  logic [tspg_pkg::PERIOD_WIDTH-1:0] tick_count,
   output tspg_pkg::axis_stat_type           stat
);

   logic [tspg_pkg::PERIOD_WIDTH-1:0] compare_ff [tspg_pkg::AXES];
   logic [tspg_pkg::PERIOD_WIDTH-1:0] compare_in [tspg_pkg::AXES];
   logic [tspg_pkg::STEP_WIDTH-1:0]   steps_ff   [tspg_pkg::AXES];
   logic [tspg_pkg::STEP_WIDTH-1:0]   steps_in   [tspg_pkg::AXES];
   logic [tspg_pkg::STEP_WIDTH-1:0]   steps_dec  [tspg_pkg::AXES];
   logic [tspg_pkg::AXES-1:0]         chan_ff, chan_in;
   logic [tspg_pkg::AXES-1:0]         busy_ff, busy_in;
   logic [tspg_pkg::AXES-1:0]         fwd_ff, fwd_in;
   logic [tspg_pkg::AXES-1:0]         dir_ff, dir_in;
   logic [tspg_pkg::AXES-1:0]         en_ff, en_in;
   logic [tspg_pkg::AXES-1:0]         sel;

   always_comb begin
      chan_in = chan_ff;
      busy_in = busy_ff;
      fwd_in  = fwd_ff;
      dir_in  = dir_ff;
      en_in   = en_ff;
      for (int i = 0; i < tspg_pkg::AXES; i++) begin
         sel[i]        = (ctl.axis == tspg_pkg::AXIS_W'(i));
         compare_in[i] = compare_ff[i];
         steps_in[i]   = steps_ff[i];
         steps_dec[i]  = steps_ff[i] - 1'b1;
         if (ctl.roll && steps_ff[i] != '0) begin
            if (ctl.limits[i] && !fwd_ff[i]) begin
               steps_in[i] = '0;
               busy_in[i]  = 1'b0;
               chan_in[i]  = 1'b0;
            end else begin
               steps_in[i] = steps_dec[i];
               if (steps_dec[i] == '0) begin
                  busy_in[i] = 1'b0;
                  chan_in[i] = 1'b0;
               end
            end
         end
         if (ctl.load_rate && sel[i]) begin
            compare_in[i] = ctl.compare;
         end
         if (ctl.load_move && sel[i]) begin
            steps_in[i] = ctl.steps;
            busy_in[i]  = 1'b1;
            chan_in[i]  = 1'b1;
         end
         if (ctl.set_dir && sel[i]) begin
            fwd_in[i] = ctl.flag;
            dir_in[i] = ctl.flag;
         end
         if (ctl.set_en && sel[i]) begin
            en_in[i] = !ctl.flag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff <= '1;
         busy_ff <= '0;
         fwd_ff  <= '1;
         dir_ff  <= '0;
         en_ff   <= '1;
         for (int i = 0; i < tspg_pkg::AXES; i++) begin
            compare_ff[i] <= tspg_pkg::COMPARE_RESET;
            steps_ff[i]   <= '0;
         end
      end else begin
         chan_ff <= chan_in;
         busy_ff <= busy_in;
         fwd_ff  <= fwd_in;
         dir_ff  <= dir_in;
         en_ff   <= en_in;
         for (int i = 0; i < tspg_pkg::AXES; i++) begin
            compare_ff[i] <= compare_in[i];
            steps_ff[i]   <= steps_in[i];
         end
      end
   end

   always_comb begin
      stat.busy      = busy_ff;
      stat.roll_busy = busy_in;
      stat.forward   = fwd_ff;
      stat.dir       = dir_ff;
      stat.enable    = en_ff;
      for (int i = 0; i < tspg_pkg::AXES; i++) begin
         stat.step[i] = chan_ff[i] && (tick_count < compare_ff[i]);
      end
   end

endmodule

// ===== rtl/core/three_axis_step_pulse_generator_top.sv =====
// Three-axis step pulse generator: shared period counter, sequencer and
// response word. Depends on tspg_pkg, tspg_div, tspg_axes, assert_macros.svh.
//
// Each request word yields exactly one response word carrying the pin levels
// and busy state after the request acts. Ticks, set direction, driver enable,
// start, stop, and moves or rate writes that need no divide are answered
// without the divider. A move or set rate with a nonzero rate runs
// 1000000 / rate on the shared bit-serial divider (20 quotient bits, one per
// cycle), and req_stall is high meanwhile. A response the sink stalls holds
// off the next request word.
`include "assert_macros.svh"

module three_axis_step_pulse_generator_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [2:0]                          req_type,
   input  logic [tspg_pkg::AXIS_W-1:0]         req_axis,
   input  logic [tspg_pkg::STEP_WIDTH-1:0]     req_step_count,
   input  logic [tspg_pkg::RATE_WIDTH-1:0]     req_rate_hz,
   input  logic                                req_flag_value,
   input  logic [tspg_pkg::AXES-1:0]           req_limit_neg,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tspg_pkg::AXES-1:0]           rsp_step_levels,
   output logic [tspg_pkg::AXES-1:0]           rsp_dir_levels,
   output logic [tspg_pkg::AXES-1:0]           rsp_enable_pins,
   output logic [tspg_pkg::AXES-1:0]           rsp_moving_axes,
   output logic                                rsp_counter_running
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_DIVIDE = 2'b10
   } state_type;

   state_type                         state_ff, state_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [tspg_pkg::PERIOD_WIDTH-1:0] tick_ff, tick_in;
   logic [tspg_pkg::PERIOD_WIDTH-1:0] reload_ff, reload_in;
   logic                              run_ff, run_in;
   logic                              pend_move_ff, pend_move_in;
   logic [tspg_pkg::AXIS_W-1:0]       pend_axis_ff, pend_axis_in;
   logic [tspg_pkg::STEP_WIDTH-1:0]   pend_steps_ff, pend_steps_in;

   tspg_pkg::axis_ctl_type            ctl;
   tspg_pkg::axis_stat_type           stat;

   logic                              accept;
   logic                              axis_ok;
   logic                              limit_hit;
   logic                              need_div;
   logic [tspg_pkg::AXES-1:0]         axis_hot;
   logic                              div_done;
   logic [tspg_pkg::QUOT_WIDTH-1:0]   quotient;
   logic [tspg_pkg::QUOT_WIDTH-1:0]   quot_fix;
   logic [tspg_pkg::QUOT_WIDTH-1:0]   quot_m1;
   logic [tspg_pkg::PERIOD_WIDTH-1:0] new_reload;
   logic [tspg_pkg::PERIOD_WIDTH:0]   reload_p1;

   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign axis_ok   = (req_axis < tspg_pkg::AXIS_W'(tspg_pkg::AXES));
   assign axis_hot  = tspg_pkg::AXES'(1) << req_axis;
   assign limit_hit = |(axis_hot & req_limit_neg & ~stat.forward);

   always_comb begin
      need_div = 1'b0;
      case (req_type)
         tspg_pkg::REQ_MOVE: need_div = axis_ok && req_step_count != '0
                                        && req_rate_hz != '0 && !limit_hit;
         tspg_pkg::REQ_RATE: need_div = axis_ok && req_rate_hz != '0;
         default:            need_div = 1'b0;
      endcase
   end

   tspg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && need_div),
      .divisor  (req_rate_hz),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      quot_fix = (quotient == '0) ? tspg_pkg::QUOT_WIDTH'(1) : quotient;
      quot_m1  = quot_fix - 1'b1;
      if (64'(quot_m1) > tspg_pkg::PERIOD_MAX) begin
         new_reload = tspg_pkg::PERIOD_WIDTH'(tspg_pkg::PERIOD_MAX);
      end else begin
         new_reload = tspg_pkg::PERIOD_WIDTH'(quot_m1);
      end
      reload_p1 = {1'b0, new_reload} + 1'b1;
   end

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      tick_in       = tick_ff;
      reload_in     = reload_ff;
      run_in        = run_ff;
      pend_move_in  = pend_move_ff;
      pend_axis_in  = pend_axis_ff;
      pend_steps_in = pend_steps_ff;

      ctl           = '0;
      ctl.limits    = req_limit_neg;
      ctl.axis      = (state_ff == ST_DIVIDE) ? pend_axis_ff : req_axis;
      ctl.flag      = req_flag_value;
      ctl.compare   = reload_p1[tspg_pkg::PERIOD_WIDTH:1];
      ctl.steps     = pend_steps_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (need_div) begin
                  state_in      = ST_DIVIDE;
                  pend_move_in  = (req_type == tspg_pkg::REQ_MOVE);
                  pend_axis_in  = req_axis;
                  pend_steps_in = req_step_count;
               end else begin
                  rsp_valid_in = 1'b1;
                  case (req_type)
                     tspg_pkg::REQ_TICK: begin
                        if (run_ff) begin
                           if (tick_ff >= reload_ff) begin
                              tick_in  = '0;
                              ctl.roll = 1'b1;
                              run_in   = |stat.roll_busy;
                           end else begin
                              tick_in = tick_ff + 1'b1;
                           end
                        end
                     end
                     tspg_pkg::REQ_RATE: begin
                        if (axis_ok) begin
                           run_in = 1'b0;
                        end
                     end
                     tspg_pkg::REQ_DIR:   ctl.set_dir = axis_ok;
                     tspg_pkg::REQ_EN:    ctl.set_en  = axis_ok;
                     tspg_pkg::REQ_START: run_in      = 1'b1;
                     tspg_pkg::REQ_STOP:  run_in      = 1'b0;
                     default:             ;
                  endcase
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               reload_in     = new_reload;
               tick_in       = '0;
               ctl.load_rate = 1'b1;
               ctl.load_move = pend_move_ff;
               if (pend_move_ff) begin
                  run_in = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         tick_ff      <= '0;
         reload_ff    <= tspg_pkg::PERIOD_RESET;
         run_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tick_ff      <= tick_in;
         reload_ff    <= reload_in;
         run_ff       <= run_in;
      end
      pend_move_ff  <= pend_move_in;
      pend_axis_ff  <= pend_axis_in;
      pend_steps_ff <= pend_steps_in;
   end

   tspg_axes u_axes (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .tick_count (tick_ff),
      .stat       (stat)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_step_levels     = stat.step;
   assign rsp_dir_levels      = stat.dir;
   assign rsp_enable_pins     = stat.enable;
   assign rsp_moving_axes     = stat.busy;
   assign rsp_counter_running = run_ff;

   // counter never passes its reload; reload only changes with the counter at zero
   `ASSERT_IMPLIES(a_tick_in_range, clock, reset, 1'b1, tick_ff <= reload_ff, "tick past reload")
   `ASSERT_IMPLIES(a_done_in_divide, clock, reset, div_done, state_ff == ST_DIVIDE, "stray divide done")
   `ASSERT_IMPLIES(a_no_rsp_in_divide, clock, reset, state_ff == ST_DIVIDE, !rsp_valid_ff, "word pending during divide")
   `ASSERT_NEXT(a_div_starts, clock, reset, accept && need_div, state_ff == ST_DIVIDE && !div_done, "divide not entered")

endmodule

// ===== tb/tspg_pin_checker.sv =====
// Checker for the three-axis step pulse generator: tracks the counter and axis
// state from accepted request words and compares every accepted response word.
// Depends on tspg_pkg for sizes, request codes and reset values.
module tspg_pin_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [2:0]                        req_type,
   input  logic [tspg_pkg::AXIS_W-1:0]       req_axis,
   input  logic [tspg_pkg::STEP_WIDTH-1:0]   req_step_count,
   input  logic [tspg_pkg::RATE_WIDTH-1:0]   req_rate_hz,
   input  logic                              req_flag_value,
   input  logic [tspg_pkg::AXES-1:0]         req_limit_neg,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [tspg_pkg::AXES-1:0]         rsp_step_levels,
   input  logic [tspg_pkg::AXES-1:0]         rsp_dir_levels,
   input  logic [tspg_pkg::AXES-1:0]         rsp_enable_pins,
   input  logic [tspg_pkg::AXES-1:0]         rsp_moving_axes,
   input  logic                              rsp_counter_running,
   output int                                fail_count,
   output int                                pending_words
);

   typedef struct packed {
      logic [tspg_pkg::AXES-1:0] step;
      logic [tspg_pkg::AXES-1:0] dir;
      logic [tspg_pkg::AXES-1:0] en_n;
      logic [tspg_pkg::AXES-1:0] moving;
      logic                      running;
   } pins_type;

   logic [tspg_pkg::PERIOD_WIDTH-1:0] period_top;
   logic [tspg_pkg::PERIOD_WIDTH-1:0] half_mark [tspg_pkg::AXES];
   logic [tspg_pkg::PERIOD_WIDTH-1:0] phase_cnt;
   logic [tspg_pkg::STEP_WIDTH-1:0]   steps_todo [tspg_pkg::AXES];
   logic [tspg_pkg::AXES-1:0]         pulse_on, busy_ax, fwd_ax, dir_ax, en_n_ax;
   logic                              counting;

   pins_type pin_queue [$];
   int       fails = 0;
   int       queued = 0;
   int       rsp_seen = 0;

   assign fail_count    = fails;
   assign pending_words = queued;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: word %0d %s: got %0h, want %0h", $time, rsp_seen, what, got, want);
      fails++;
   endtask

   // shared period reload and this axis's half-period compare; rate zero only stops
   function automatic void load_period(input int ax,
                                       input logic [tspg_pkg::RATE_WIDTH-1:0] hz);
      longint unsigned q;
      if (hz == 0) begin
         counting = 1'b0;
      end else begin
         q = longint'(tspg_pkg::BASE_HZ) / hz;
         if (q == 0) q = 1;
         q = q - 1;
         if (q > tspg_pkg::PERIOD_MAX) q = tspg_pkg::PERIOD_MAX;
         period_top    = q[tspg_pkg::PERIOD_WIDTH-1:0];
         half_mark[ax] = tspg_pkg::PERIOD_WIDTH'((q + 1) >> 1);
         phase_cnt     = '0;
      end
   endfunction

   function automatic pins_type apply_word(input logic [2:0] t,
                                           input logic [tspg_pkg::AXIS_W-1:0] ax_in,
                                           input logic [tspg_pkg::STEP_WIDTH-1:0] sc,
                                           input logic [tspg_pkg::RATE_WIDTH-1:0] hz,
                                           input logic fl,
                                           input logic [tspg_pkg::AXES-1:0] lim);
      pins_type p;
      bit       ok;
      bit       any;
      int       ax;
      ok = ax_in < tspg_pkg::AXES;
      ax = ok ? int'(ax_in) : 0;
      case (t)
         tspg_pkg::REQ_TICK: begin
            if (counting) begin
               if (phase_cnt >= period_top) begin
                  phase_cnt = '0;
                  any = 1'b0;
                  for (int i = 0; i < tspg_pkg::AXES; i++) begin
                     if (steps_todo[i] != 0) begin
                        if (!fwd_ax[i] && lim[i]) begin
                           steps_todo[i] = '0;
                           busy_ax[i]    = 1'b0;
                           pulse_on[i]   = 1'b0;
                        end else begin
                           steps_todo[i] = steps_todo[i] - 1;
                           if (steps_todo[i] == 0) begin
                              busy_ax[i]  = 1'b0;
                              pulse_on[i] = 1'b0;
                           end
                        end
                     end
                     any |= busy_ax[i];
                  end
                  if (!any) counting = 1'b0;
               end else begin
                  phase_cnt = phase_cnt + 1'b1;
               end
            end
         end
         tspg_pkg::REQ_MOVE: begin
            if (ok && sc != 0 && hz != 0 && !(!fwd_ax[ax] && lim[ax])) begin
               load_period(ax, hz);
               steps_todo[ax] = sc;
               busy_ax[ax]    = 1'b1;
               pulse_on[ax]   = 1'b1;
               counting       = 1'b1;
            end
         end
         tspg_pkg::REQ_DIR: begin
            if (ok) begin
               fwd_ax[ax] = fl;
               dir_ax[ax] = fl;
            end
         end
         tspg_pkg::REQ_RATE: begin
            if (ok) load_period(ax, hz);
         end
         tspg_pkg::REQ_EN: begin
            if (ok) en_n_ax[ax] = !fl;
         end
         tspg_pkg::REQ_START: counting = 1'b1;
         tspg_pkg::REQ_STOP:  counting = 1'b0;
         default: ;
      endcase
      for (int i = 0; i < tspg_pkg::AXES; i++)
         p.step[i] = pulse_on[i] && (phase_cnt < half_mark[i]);
      p.dir     = dir_ax;
      p.en_n    = en_n_ax;
      p.moving  = busy_ax;
      p.running = counting;
      return p;
   endfunction

   always @(posedge clock) begin
      pins_type want;
      if (reset) begin
         period_top = tspg_pkg::PERIOD_RESET;
         phase_cnt  = '0;
         counting   = 1'b0;
         pulse_on   = '1;
         busy_ax    = '0;
         fwd_ax     = '1;
         dir_ax     = '0;
         en_n_ax    = '1;
         for (int i = 0; i < tspg_pkg::AXES; i++) begin
            half_mark[i]  = tspg_pkg::COMPARE_RESET;
            steps_todo[i] = '0;
         end
         pin_queue.delete();
      end else begin
         if (req_valid && !req_stall)
            pin_queue.push_back(apply_word(req_type, req_axis, req_step_count, req_rate_hz,
                                           req_flag_value, req_limit_neg));
         if (rsp_valid && !rsp_stall) begin
            if (pin_queue.size() == 0) begin
               report_mismatch("response word with none expected", 32'd0, 32'd0);
            end else begin
               want = pin_queue.pop_front();
               if (rsp_step_levels !== want.step)
                  report_mismatch("step_levels", 32'(rsp_step_levels), 32'(want.step));
               if (rsp_dir_levels !== want.dir)
                  report_mismatch("dir_levels", 32'(rsp_dir_levels), 32'(want.dir));
               if (rsp_enable_pins !== want.en_n)
                  report_mismatch("enable_pins", 32'(rsp_enable_pins), 32'(want.en_n));
               if (rsp_moving_axes !== want.moving)
                  report_mismatch("moving_axes", 32'(rsp_moving_axes), 32'(want.moving));
               if (rsp_counter_running !== want.running)
                  report_mismatch("counter_running", 32'(rsp_counter_running),
                                  32'(want.running));
            end
            rsp_seen++;
         end
      end
      queued <= pin_queue.size();
   end

endmodule

// ===== tb/three_axis_step_pulse_generator_top_tb.sv =====
// Testbench top for the three-axis step pulse generator: clock, reset, request
// stimulus and response stalls. Depends on tspg_pkg, the RTL and tspg_pin_checker.
module three_axis_step_pulse_generator_top_tb;

   localparam logic [2:0] REQ_UNUSED = 3'd7;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [2:0]                        req_type = tspg_pkg::REQ_TICK;
   logic [tspg_pkg::AXIS_W-1:0]       req_axis = '0;
   logic [tspg_pkg::STEP_WIDTH-1:0]   req_step_count = '0;
   logic [tspg_pkg::RATE_WIDTH-1:0]   req_rate_hz = '0;
   logic                              req_flag_value = 1'b0;
   logic [tspg_pkg::AXES-1:0]         req_limit_neg = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [tspg_pkg::AXES-1:0]         rsp_step_levels, rsp_dir_levels;
   logic [tspg_pkg::AXES-1:0]         rsp_enable_pins, rsp_moving_axes;
   logic                              rsp_counter_running;

   int fail_count, pending_words;
   int send_idle_pct = 0;
   int sink_stall_pct = 0;
   int words_sent = 0;

   three_axis_step_pulse_generator_top u_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_type, .req_axis, .req_step_count, .req_rate_hz,
      .req_flag_value, .req_limit_neg,
      .rsp_valid, .rsp_stall, .rsp_step_levels, .rsp_dir_levels, .rsp_enable_pins,
      .rsp_moving_axes, .rsp_counter_running
   );

   tspg_pin_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_type, .req_axis, .req_step_count, .req_rate_hz,
      .req_flag_value, .req_limit_neg,
      .rsp_valid, .rsp_stall, .rsp_step_levels, .rsp_dir_levels, .rsp_enable_pins,
      .rsp_moving_axes, .rsp_counter_running,
      .fail_count, .pending_words
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < sink_stall_pct);
   end

   task automatic send_word(input logic [2:0] t, input logic [tspg_pkg::AXIS_W-1:0] ax,
                            input logic [tspg_pkg::STEP_WIDTH-1:0] sc,
                            input logic [tspg_pkg::RATE_WIDTH-1:0] hz,
                            input logic fl, input logic [tspg_pkg::AXES-1:0] lim);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= t;
      req_axis       <= ax;
      req_step_count <= sc;
      req_rate_hz    <= hz;
      req_flag_value <= fl;
      req_limit_neg  <= lim;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   function automatic logic [tspg_pkg::AXES-1:0] pick_limits();
      return ($urandom_range(3) == 0) ? tspg_pkg::AXES'($urandom_range(7)) : '0;
   endfunction

   task automatic send_noise();
      send_word(3'($urandom_range(7)), tspg_pkg::AXIS_W'($urandom_range(3)), $urandom,
                tspg_pkg::RATE_WIDTH'($urandom_range(1000000)), 1'($urandom_range(1)),
                pick_limits());
   endtask

   // setup, a move (mostly short) at a high rate, then a run of ticks with sparse commands
   task automatic motion_burst();
      logic [tspg_pkg::AXIS_W-1:0]     ax;
      logic [tspg_pkg::STEP_WIDTH-1:0] steps;
      int                              n;
      ax = tspg_pkg::AXIS_W'($urandom_range(2));
      if ($urandom_range(3) == 0)
         send_word(tspg_pkg::REQ_DIR, ax, $urandom, '0, 1'($urandom_range(1)), pick_limits());
      if ($urandom_range(3) == 0)
         send_word(tspg_pkg::REQ_EN, ax, $urandom, '0, 1'($urandom_range(1)), pick_limits());
      steps = ($urandom_range(9) == 0) ? $urandom
                                       : tspg_pkg::STEP_WIDTH'($urandom_range(1, 6));
      send_word(tspg_pkg::REQ_MOVE, ax, steps,
                tspg_pkg::RATE_WIDTH'($urandom_range(100000, 1000000)),
                1'($urandom_range(1)), pick_limits());
      n = $urandom_range(4, 30);
      repeat (n) begin
         case ($urandom_range(24))
            0: send_word(tspg_pkg::REQ_MOVE, tspg_pkg::AXIS_W'($urandom_range(2)),
                         tspg_pkg::STEP_WIDTH'($urandom_range(1, 4)),
                         tspg_pkg::RATE_WIDTH'($urandom_range(100000, 1000000)), 1'b0,
                         pick_limits());
            1: send_word(tspg_pkg::REQ_RATE, tspg_pkg::AXIS_W'($urandom_range(2)), $urandom,
                         tspg_pkg::RATE_WIDTH'($urandom_range(100000, 1000000)), 1'b0,
                         pick_limits());
            2: send_word(tspg_pkg::REQ_STOP, ax, $urandom, '0, 1'b0, '0);
            3: send_word(tspg_pkg::REQ_START, ax, $urandom, '0, 1'b0, '0);
            default: send_word(tspg_pkg::REQ_TICK, tspg_pkg::AXIS_W'($urandom_range(3)),
                               $urandom, tspg_pkg::RATE_WIDTH'($urandom_range(1000000)),
                               1'($urandom_range(1)), pick_limits());
         endcase
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct  = 17;
      sink_stall_pct = 86;

      // stopped counter, unused code, enables and directions incl. bad axis
      send_word(tspg_pkg::REQ_TICK, '0, '0, '0, 1'b0, '0);
      send_word(REQ_UNUSED, '1, '1, '1, 1'b1, '1);
      send_word(tspg_pkg::REQ_EN, 2'd0, '0, '0, 1'b1, '0);
      send_word(tspg_pkg::REQ_EN, 2'd3, '0, '0, 1'b1, '0);
      send_word(tspg_pkg::REQ_DIR, 2'd1, '0, '0, 1'b0, '0);
      // ignored moves: backward into limit, zero steps, zero rate
      send_word(tspg_pkg::REQ_MOVE, 2'd1, 32'd5, 20'd1000, 1'b0, 3'b010);
      send_word(tspg_pkg::REQ_MOVE, 2'd0, '0, 20'd1000, 1'b0, '0);
      send_word(tspg_pkg::REQ_MOVE, 2'd0, 32'd3, '0, 1'b0, '0);
      // saturated period, rate above base, rate zero
      send_word(tspg_pkg::REQ_RATE, 2'd2, '0, 20'd1, 1'b0, '0);
      send_word(tspg_pkg::REQ_RATE, 2'd2, '0, '1, 1'b0, '0);
      send_word(tspg_pkg::REQ_RATE, 2'd0, '0, '0, 1'b0, '0);
      // two steps at period 2, run to completion
      send_word(tspg_pkg::REQ_MOVE, 2'd0, 32'd2, 20'd500000, 1'b0, '0);
      repeat (5) send_word(tspg_pkg::REQ_TICK, '0, '0, '0, 1'b0, '0);
      // backward max-count move cut by the limit switch
      send_word(tspg_pkg::REQ_MOVE, 2'd1, '1, 20'd1000000, 1'b0, '0);
      send_word(tspg_pkg::REQ_TICK, '0, '0, '0, 1'b0, '0);
      send_word(tspg_pkg::REQ_TICK, '0, '0, '0, 1'b0, 3'b010);
      // start with nothing busy stops at next rollover
      send_word(tspg_pkg::REQ_START, '0, '0, '0, 1'b0, '0);
      send_word(tspg_pkg::REQ_TICK, '0, '0, '0, 1'b0, '0);
      send_word(tspg_pkg::REQ_STOP, '0, '0, '0, 1'b0, '0);
      send_word(tspg_pkg::REQ_DIR, 2'd3, '0, '0, 1'b1, '0);

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct  = (ph == 0) ? 17 : (ph == 1) ? 86 : 0;
         sink_stall_pct = (ph == 0) ? 86 : (ph == 1) ? 17 : 0;
         while (words_sent < 24 + 140 * (ph + 1)) begin
            if ($urandom_range(3) == 0) send_noise();
            else motion_burst();
         end
      end
      req_valid <= 1'b0;

      while (pending_words != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_words == 0)
         $display("[three_axis_step_pulse_generator_top] OK");
      else
         $display("[three_axis_step_pulse_generator_top] ERROR");
      $finish;
   end

   initial begin
      #6000000;
      $display("[three_axis_step_pulse_generator_top] ERROR");
      $finish;
   end

endmodule
